// File: design/ptts_pkg.sv
package ptts_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
	localparam int SLOT_W         = 3;
	localparam int OVF_W          = 16;
	localparam int LOW_W          = 8;
	localparam int TIME_W         = OVF_W + LOW_W;
	localparam int INTV_W         = 16;
	localparam int TAG_W          = 8;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_CREATE = 1'b1;
	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	typedef enum logic [1:0] {
		ST_EMPTY  = 2'd0,
		ST_ONCE   = 2'd1,
		ST_REPEAT = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CR_SCAN,
		S_CR_WRITE,
		S_TK_READ,
		S_TK_EVAL,
		S_TK_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic              mode;
		logic [LOW_W-1:0]  timer_low;
		logic [INTV_W-1:0] interval;
		logic              repeating;
		logic [TAG_W-1:0]  task_tag;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  fired_tag;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic create_step;
		logic create_commit;
		logic tick_read;
		logic tick_eval;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_create;
		logic create_done;
		logic eval_blocked;
		logic eval_end;
		logic out_free;
		logic pend_valid;
	} dp_stat_t;

endpackage

// File: design/periodic_task_table_scheduler.sv
// channel  signals                        transfer when
// in       in_valid, in_ready, in_item    in_valid && in_ready
// out      out_valid, out_ready, out_item out_valid && out_ready
//
// one item at a time; in_ready is high only while the controller is idle
// create: a search of up to SLOT_COUNT slots, one slot per cycle, then a write that waits on the output register
// tick: per slot a table read, then compare and update, stopping at the last slot or at the
// MAX_RESULTS-th firing, then a flush of the last firing; each firing waits on the output register
// reset empties every slot and clears the overflow count, no clearing pass
module periodic_task_table_scheduler #(
	parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptts_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ptts_pkg::out_item_t out_item
);

	ptts_pkg::dp_cmd_t  cmd;
	ptts_pkg::dp_stat_t stat;

	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptts_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

// File: design/ptts_ctrl.sv
module ptts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptts_pkg::dp_stat_t stat,
	output ptts_pkg::dp_cmd_t  cmd
);

	ptts_pkg::ctrl_state_t state_q;
	ptts_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ptts_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = stat.in_is_create ? ptts_pkg::S_CR_SCAN : ptts_pkg::S_TK_READ;
				end
			end
			ptts_pkg::S_CR_SCAN: begin
				cmd.create_step = 1'b1;
				if (stat.create_done) begin
					state_d = ptts_pkg::S_CR_WRITE;
				end
			end
			ptts_pkg::S_CR_WRITE: begin
				if (stat.out_free) begin
					cmd.create_commit = 1'b1;
					state_d = ptts_pkg::S_IDLE;
				end
			end
			ptts_pkg::S_TK_READ: begin
				cmd.tick_read = 1'b1;
				state_d = ptts_pkg::S_TK_EVAL;
			end
			ptts_pkg::S_TK_EVAL: begin
				if (!stat.eval_blocked) begin
					cmd.tick_eval = 1'b1;
					state_d = stat.eval_end ? ptts_pkg::S_TK_FLUSH : ptts_pkg::S_TK_READ;
				end
			end
			ptts_pkg::S_TK_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ptts_pkg::S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d = ptts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptts_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: design/ptts_dp.sv
module ptts_dp #(
	parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptts_pkg::in_item_t  in_item,
	input  ptts_pkg::dp_cmd_t   cmd,
	output ptts_pkg::dp_stat_t  stat,
	input  logic                out_ready,
	output logic                out_valid,
	output ptts_pkg::out_item_t out_item
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	ptts_pkg::slot_st_t status_q [SLOT_COUNT];
	logic               ran_q    [SLOT_COUNT];

	logic [ptts_pkg::TIME_W-1:0] ctime_mem [SLOT_COUNT];
	logic [ptts_pkg::INTV_W-1:0] intv_mem  [SLOT_COUNT];
	logic [ptts_pkg::TAG_W-1:0]  tag_mem   [SLOT_COUNT];

	logic [ptts_pkg::TIME_W-1:0] ctime_rd_q;
	logic [ptts_pkg::INTV_W-1:0] intv_rd_q;
	logic [ptts_pkg::TAG_W-1:0]  tag_rd_q;

	ptts_pkg::in_item_t          item_q;
	logic [ptts_pkg::OVF_W-1:0]  ovf_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            sel_q;
	logic [ptts_pkg::CNT_W-1:0]  cnt_q;
	logic                        pend_valid_q;
	logic [ptts_pkg::SLOT_W-1:0] pend_slot_q;
	logic [ptts_pkg::TAG_W-1:0]  pend_tag_q;
	logic                        out_valid_q;
	ptts_pkg::out_item_t         out_q;

	ptts_pkg::slot_st_t          st;
	logic [ptts_pkg::TIME_W-1:0] now;
	logic [ptts_pkg::TIME_W:0]   due_at;
	logic                        active;
	logic                        due;
	logic                        hit;
	logic                        idx_last;
	logic                        out_free;
	logic                        fire;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_wa;
	logic                        out_load;
	ptts_pkg::out_item_t         out_next;

	assign st       = status_q[idx_q];
	assign now      = {ovf_q, item_q.timer_low};
	assign due_at   = {1'b0, ctime_rd_q} + (ptts_pkg::TIME_W + 1)'(intv_rd_q);
	assign active   = (st == ptts_pkg::ST_ONCE && !ran_q[idx_q]) || st == ptts_pkg::ST_REPEAT;
	assign due      = active && ({1'b0, now} > due_at);
	assign hit      = !(st == ptts_pkg::ST_ONCE || st == ptts_pkg::ST_REPEAT)
			|| (st == ptts_pkg::ST_ONCE && ran_q[idx_q]);
	assign idx_last = idx_q == IDX_W'(SLOT_COUNT - 1);
	assign out_free = !out_valid_q || out_ready;
	assign fire     = cmd.tick_eval && due;

	assign stat.in_is_create = in_item.mode == ptts_pkg::MODE_CREATE;
	assign stat.create_done  = hit || idx_last;
	assign stat.eval_blocked = due && pend_valid_q && !out_free;
	assign stat.eval_end     = idx_last
			|| (due && cnt_q == ptts_pkg::CNT_W'(ptts_pkg::MAX_RESULTS - 1));
	assign stat.out_free     = out_free;
	assign stat.pend_valid   = pend_valid_q;

	// table stores
	assign mem_we = cmd.create_commit || (fire && st == ptts_pkg::ST_REPEAT);
	assign mem_wa = cmd.create_commit ? sel_q : idx_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ctime_mem[mem_wa] <= now;
		end
		if (cmd.create_commit) begin
			intv_mem[sel_q] <= item_q.interval;
			tag_mem[sel_q]  <= item_q.task_tag;
		end
		if (cmd.tick_read) begin
			ctime_rd_q <= ctime_mem[idx_q];
			intv_rd_q  <= intv_mem[idx_q];
			tag_rd_q   <= tag_mem[idx_q];
		end
	end

	// result selection
	always_comb begin
		out_load = 1'b0;
		out_next = out_q;
		if (cmd.create_commit) begin
			out_load = 1'b1;
			out_next = '{kind: ptts_pkg::KIND_CREATE, slot: ptts_pkg::SLOT_W'(sel_q),
					fired_tag: item_q.task_tag, last: 1'b1};
		end else if (fire && pend_valid_q) begin
			out_load = 1'b1;
			out_next = '{kind: ptts_pkg::KIND_FIRE, slot: pend_slot_q,
					fired_tag: pend_tag_q, last: 1'b0};
		end else if (cmd.flush) begin
			out_load = 1'b1;
			out_next = '{kind: ptts_pkg::KIND_FIRE, slot: pend_slot_q,
					fired_tag: pend_tag_q, last: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (out_load) begin
			out_q <= out_next;
		end
		if (fire) begin
			pend_slot_q <= ptts_pkg::SLOT_W'(idx_q);
			pend_tag_q  <= tag_rd_q;
		end
		if (cmd.create_step) begin
			if (hit) begin
				sel_q <= idx_q;
			end else if (idx_last) begin
				sel_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				status_q[i] <= ptts_pkg::ST_EMPTY;
				ran_q[i]    <= 1'b0;
			end
			ovf_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
				if (in_item.mode == ptts_pkg::MODE_TICK) begin
					ovf_q <= ovf_q + 1'b1;
				end
			end
			if (cmd.create_step && !hit && !idx_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.create_commit) begin
				status_q[sel_q] <= item_q.repeating ? ptts_pkg::ST_REPEAT : ptts_pkg::ST_ONCE;
				ran_q[sel_q]    <= 1'b0;
			end
			if (cmd.tick_eval) begin
				if (!idx_last) begin
					idx_q <= idx_q + 1'b1;
				end
				if (due) begin
					ran_q[idx_q] <= 1'b1;
					pend_valid_q <= 1'b1;
					cnt_q        <= cnt_q + 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
